// ===== rtl/mcd_pkg.sv =====
`default_nettype none
package mcd_pkg;

   // Button count and the mask of valid button bits
   localparam int BUTTON_BITS = 8;
   localparam logic [7:0] BUTTON_MASK =
      (BUTTON_BITS >= 8) ? 8'hFF : 8'((1 << BUTTON_BITS) - 1);

   // Window growth per extra click, and pointer slack in pixels
   localparam logic [15:0] EXTEND_TICKS = 16'd3;
   localparam logic signed [16:0] MOVE_SLACK = 17'sd2;
   localparam logic [15:0] WINDOW_RESET = 16'd5;
   localparam logic [7:0]  TALLY_MAX = 8'hFF;

   typedef enum logic [1:0] {
      KIND_BUTTON = 2'd0,
      KIND_TICK   = 2'd1,
      KIND_MOVE   = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   // One input transaction
   typedef struct packed {
      kind_type           kind;
      logic [7:0]         buttons;
      logic [7:0]         tick_amount;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic               multi_click_wanted;
   } item_type;

   // One result transaction
   typedef struct packed {
      logic [7:0] event_buttons;
      logic [7:0] event_clicks;
      logic       last;
   } res_type;

   // Results of one item, handed to the output buffer
   typedef struct packed {
      logic [1:0] count;
      res_type    r0;
      res_type    r1;
   } push_type;

endpackage
`default_nettype wire

// ===== rtl/multi_click_detector.sv =====
// Channel   Direction  Handshake            Payload
// req_      in         req_tvalid/tready    tdata: item fields, tuser: kind
// rsp_      out        rsp_tvalid/tready    tdata: buttons, clicks; tlast
// csr_      in         csr_we               csr_wdata: click window
//
// An item waits in the input register, and its results are loaded into the
// output buffer on the edge at which it leaves that register. One item per
// cycle while each gives at most one result and the result side does not
// stall; an item giving two results holds the input while the pair drains.
// Reset is synchronous; after it the block accepts at once. A stalled result
// side fills the buffer and then holds req_tready low.
`default_nettype none
module multi_click_detector (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // buttons[7:0], tick_amount[15:8], pos_x[31:16], pos_y[47:32],
   // multi_click_wanted[48], zero[55:49]
   input  wire logic [55:0] req_tdata,
   // kind[1:0]
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // event_buttons[7:0], event_clicks[15:8]
   output logic [15:0]      rsp_tdata,
   output logic             rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata
);
   import mcd_pkg::*;

   logic [15:0] click_window_ff;
   logic        in_valid_ff;
   item_type    item_ff, item_in;
   logic        advance;
   logic        can_take;
   push_type    push;
   res_type     out_res;

   // Click window register
   always_ff @(posedge clock) begin
      if (reset) begin
         click_window_ff <= WINDOW_RESET;
      end else if (csr_we) begin
         click_window_ff <= csr_wdata;
      end
   end

   // Input register
   assign advance    = in_valid_ff && can_take;
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      item_in.kind               = kind_type'(req_tuser);
      item_in.buttons            = req_tdata[7:0];
      item_in.tick_amount        = req_tdata[15:8];
      item_in.pos_x              = req_tdata[31:16];
      item_in.pos_y              = req_tdata[47:32];
      item_in.multi_click_wanted = req_tdata[48];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff <= item_in;
      end
   end

   mcd_step u_step (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .item         (item_ff),
      .click_window (click_window_ff),
      .push         (push)
   );

   mcd_out_buf u_out (
      .clock     (clock),
      .reset     (reset),
      .push_en   (in_valid_ff),
      .push      (push),
      .can_take  (can_take),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_res   (out_res)
   );

   assign rsp_tdata = {out_res.event_clicks, out_res.event_buttons};
   assign rsp_tlast = out_res.last;

endmodule
`default_nettype wire

// ===== rtl/mcd_step.sv =====
`default_nettype none
module mcd_step (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             advance,
   input  wire mcd_pkg::item_type item,
   input  wire logic [15:0]      click_window,
   output mcd_pkg::push_type     push
);
   import mcd_pkg::*;

   logic [7:0]         true_buttons_ff, true_buttons_in;
   logic [7:0]         desired_buttons_ff, desired_buttons_in;
   logic [7:0]         click_tally_ff, click_tally_in;
   logic [15:0]        window_left_ff, window_left_in;
   logic signed [15:0] pointer_x_ff, pointer_x_in;
   logic signed [15:0] pointer_y_ff, pointer_y_in;

   logic [7:0]         btn;
   logic               win_open;
   logic [16:0]        win_ext;
   logic [15:0]        win_ext_sat;
   logic [15:0]        tick16;
   logic signed [16:0] dx, dy;
   logic               far;
   logic               close_win;
   logic               two_res;

   // Shared terms
   always_comb begin
      btn         = item.buttons & BUTTON_MASK;
      win_open    = (window_left_ff != 16'd0);
      win_ext     = {1'b0, window_left_ff} + {1'b0, EXTEND_TICKS};
      win_ext_sat = win_ext[16] ? 16'hFFFF : win_ext[15:0];
      tick16      = {8'd0, item.tick_amount};
      dx          = {pointer_x_ff[15], pointer_x_ff} - {item.pos_x[15], item.pos_x};
      dy          = {pointer_y_ff[15], pointer_y_ff} - {item.pos_y[15], item.pos_y};
      far         = (dx > MOVE_SLACK) || (dx < -MOVE_SLACK) ||
                    (dy > MOVE_SLACK) || (dy < -MOVE_SLACK);
   end

   // Next state and results for the item at hand
   always_comb begin
      true_buttons_in    = true_buttons_ff;
      desired_buttons_in = desired_buttons_ff;
      click_tally_in     = click_tally_ff;
      window_left_in     = window_left_ff;
      pointer_x_in       = pointer_x_ff;
      pointer_y_in       = pointer_y_ff;
      close_win          = 1'b0;
      push               = '0;
      push.r0.event_buttons = btn;
      push.r0.event_clicks  = 8'd1;
      push.r0.last          = 1'b1;

      unique case (item.kind)
         KIND_BUTTON: begin
            if (btn != true_buttons_ff) begin
               if (win_open) begin
                  if (btn == desired_buttons_ff) begin
                     if (click_tally_ff != TALLY_MAX) begin
                        click_tally_in = click_tally_ff + 8'd1;
                     end
                     window_left_in = win_ext_sat;
                  end
               end else if (item.multi_click_wanted && (btn != 8'd0)) begin
                  click_tally_in     = 8'd1;
                  desired_buttons_in = btn;
                  window_left_in     = (click_window != 16'd0) ? click_window : 16'd1;
               end else begin
                  push.count = 2'd1;
               end
               true_buttons_in = btn;
            end
         end
         KIND_TICK: begin
            if (win_open && (item.tick_amount != 8'd0)) begin
               if (tick16 >= window_left_ff) begin
                  close_win = 1'b1;
               end else begin
                  window_left_in = window_left_ff - tick16;
               end
            end
         end
         KIND_MOVE: begin
            close_win    = win_open && far;
            pointer_x_in = item.pos_x;
            pointer_y_in = item.pos_y;
         end
         default: begin
         end
      endcase

      // Report desired state, then the true state if it differs
      if (close_win) begin
         two_res               = (desired_buttons_ff != true_buttons_ff);
         window_left_in        = 16'd0;
         push.count            = two_res ? 2'd2 : 2'd1;
         push.r0.event_buttons = desired_buttons_ff;
         push.r0.event_clicks  = click_tally_ff;
         push.r0.last          = !two_res;
         push.r1.event_buttons = true_buttons_ff;
         push.r1.event_clicks  = 8'd1;
         push.r1.last          = 1'b1;
      end else begin
         two_res = 1'b0;
      end
   end

   // Commit state when the item leaves the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         true_buttons_ff    <= '0;
         desired_buttons_ff <= '0;
         click_tally_ff     <= '0;
         window_left_ff     <= '0;
         pointer_x_ff       <= '0;
         pointer_y_ff       <= '0;
      end else if (advance) begin
         true_buttons_ff    <= true_buttons_in;
         desired_buttons_ff <= desired_buttons_in;
         click_tally_ff     <= click_tally_in;
         window_left_ff     <= window_left_in;
         pointer_x_ff       <= pointer_x_in;
         pointer_y_ff       <= pointer_y_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/mcd_out_buf.sv =====
`default_nettype none
module mcd_out_buf (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_en,
   input  wire mcd_pkg::push_type push,
   output logic                  can_take,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output mcd_pkg::res_type      out_res
);
   import mcd_pkg::*;

   logic [1:0] count_ff, count_in;
   res_type    e0_ff, e0_in;
   res_type    e1_ff, e1_in;
   logic       pop;

   assign out_valid = (count_ff != 2'd0);
   assign out_res   = e0_ff;
   assign pop       = out_valid && out_ready;
   // Room for a full pair once the current head has gone
   assign can_take  = (count_ff == 2'd0) || ((count_ff == 2'd1) && pop);

   // Shift on pop; load a fresh pair when empty or when the last entry pops
   always_comb begin
      count_in = count_ff;
      e0_in    = e0_ff;
      e1_in    = e1_ff;
      if (push_en && can_take) begin
         count_in = push.count;
         e0_in    = push.r0;
         e1_in    = push.r1;
      end else if (pop) begin
         count_in = count_ff - 2'd1;
         e0_in    = e1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      e0_ff <= e0_in;
      e1_ff <= e1_in;
   end

endmodule
`default_nettype wire

// ===== rtl/mcd_checker.sv =====
`default_nettype none
module mcd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic        rsp_tlast
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // Never report zero clicks
   a_clicks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:8] != 8'd0)
      else $error("result with zero clicks");

   // Drop all results on reset
   a_rst_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result after reset");

   // Take transactions straight after reset
   a_rst_ready: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("not ready after reset");

endmodule

bind multi_click_detector mcd_checker u_mcd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire
